FILE: hw/rtl/soe_pkg.sv
// Shared types and constants for the set operation engine.
// No dependencies; imported by soe_core, set_operation_engine_unit and the testbench.
package soe_pkg;

	localparam int DEF_SET_CAPACITY = 16;
	localparam int DEF_UNIVERSE_END = 100;

	// input item kinds
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_FETCH  = 2'd3;

	// operation codes
	localparam logic [2:0] OP_UNION     = 3'd0;
	localparam logic [2:0] OP_INTERSECT = 3'd1;
	localparam logic [2:0] OP_DIFF      = 3'd2;
	localparam logic [2:0] OP_SYMDIFF   = 3'd3;
	localparam logic [2:0] OP_PRODUCT   = 3'd4;
	localparam logic [2:0] OP_COMPLEMENT = 3'd5;

	// register indexes
	localparam logic REG_OPERATION     = 1'b0;
	localparam logic REG_ORDER_B_FIRST = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] element;
	} soe_req_t;

	typedef struct packed {
		logic [2:0] operation;
		logic       order_b_first;
	} soe_cfg_t;

	typedef struct packed {
		logic [15:0] first_value;
		logic [15:0] second_value;
		logic        valid_res;
		logic        last;
	} soe_res_t;

endpackage

FILE: hw/rtl/soe_core.sv
// Set storage and result sequencer: two set memories, element counts, result cursors.
// Depends on soe_pkg.
module soe_core import soe_pkg::*; #(
	parameter int SET_CAPACITY = DEF_SET_CAPACITY,
	parameter int UNIVERSE_END = DEF_UNIVERSE_END
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  soe_req_t req,
	output logic     req_ready,
	input  soe_cfg_t cfg,
	input  logic     rewind,
	output logic     res_valid,
	output soe_res_t res,
	input  logic     res_ready
);

	localparam int NW   = $clog2(SET_CAPACITY + 1);
	localparam int AW   = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam int UW   = $clog2(UNIVERSE_END);
	localparam int OW   = (UW > NW) ? UW : NW;
	localparam int CMPW = ((OW > 16) ? OW : 16) + 1;

	localparam logic [NW-1:0] CAP  = NW'(SET_CAPACITY);
	localparam logic [OW:0]   UNIV = (OW + 1)'(UNIVERSE_END);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_PROD  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [1:0] MODE_ALL   = 2'd0;
	localparam logic [1:0] MODE_IN    = 2'd1;
	localparam logic [1:0] MODE_NOTIN = 2'd2;

	logic [15:0] mem_a [SET_CAPACITY];
	logic [15:0] mem_b [SET_CAPACITY];
	logic [15:0] a_rd_q, b_rd_q;
	logic          re_a, re_b, we_a, we_b;
	logic [AW-1:0] ra_a, ra_b;

	logic [2:0]    state_q, state_d;
	logic          peek_q, peek_d;
	logic          w_ph_q, w_ph_d, c_ph_q, c_ph_d;
	logic [OW-1:0] w_ou_q, w_ou_d, c_ou_q, c_ou_d;
	logic [NW-1:0] w_in_q, w_in_d, c_in_q, c_in_d;
	logic [NW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic [AW-1:0] j_q, j_d;
	logic [OW-1:0] p_q, p_d;
	logic          comp_q, comp_d;
	logic [1:0]    mode_q, mode_d;
	logic          scan_b_q, scan_b_d;
	soe_res_t      res_q, res_d;

	logic          ps_valid, ps_src_a, ps1_valid;
	logic [1:0]    ps_mode;
	logic [NW-1:0] cx, cy, ns, no, scan_n;
	logic [15:0]   x_rd, y_rd, scan_rd, src_rd;
	logic [CMPW-1:0] cand, scan_val;
	logic          hit;
	logic          fin, fin_found;
	logic [15:0]   fin_f, fin_s;
	logic          fin_ph;
	logic [OW-1:0] fin_ou;
	logic [NW-1:0] fin_in;
	logic [NW:0]   in_inc;

	always_ff @(posedge clk) begin
		if (we_a) mem_a[cnt_a_q[AW-1:0]] <= req.element;
		if (re_a) a_rd_q <= mem_a[ra_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) mem_b[cnt_b_q[AW-1:0]] <= req.element;
		if (re_b) b_rd_q <= mem_b[ra_b];
	end

	always_comb begin
		ps_valid  = 1'b0;
		ps_src_a  = 1'b1;
		ps_mode   = MODE_NOTIN;
		ps1_valid = (cfg.operation == OP_UNION) || (cfg.operation == OP_SYMDIFF);
		case (cfg.operation)
			OP_UNION: begin
				ps_valid = 1'b1;
				ps_src_a = !w_ph_q;
				ps_mode  = w_ph_q ? MODE_NOTIN : MODE_ALL;
			end
			OP_INTERSECT: begin
				ps_valid = !w_ph_q;
				ps_mode  = MODE_IN;
			end
			OP_DIFF: begin
				ps_valid = !w_ph_q;
				ps_src_a = !cfg.order_b_first;
			end
			OP_SYMDIFF: begin
				ps_valid = 1'b1;
				ps_src_a = !w_ph_q;
			end
			default: begin
				ps_valid = 1'b0;
			end
		endcase
	end

	assign cx       = cfg.order_b_first ? cnt_b_q : cnt_a_q;
	assign cy       = cfg.order_b_first ? cnt_a_q : cnt_b_q;
	assign ns       = ps_src_a ? cnt_a_q : cnt_b_q;
	assign no       = ps_src_a ? cnt_b_q : cnt_a_q;
	assign x_rd     = cfg.order_b_first ? b_rd_q : a_rd_q;
	assign y_rd     = cfg.order_b_first ? a_rd_q : b_rd_q;
	assign scan_rd  = scan_b_q ? b_rd_q : a_rd_q;
	assign src_rd   = scan_b_q ? a_rd_q : b_rd_q;
	assign scan_n   = scan_b_q ? cnt_b_q : cnt_a_q;
	assign cand     = comp_q ? CMPW'(p_q) : {{(CMPW-16){src_rd[15]}}, src_rd};
	assign scan_val = {{(CMPW-16){scan_rd[15]}}, scan_rd};
	assign hit      = (scan_val == cand);
	assign in_inc   = (NW + 1)'(w_in_q) + 1'b1;

	always_comb begin
		state_d  = state_q;
		peek_d   = peek_q;
		w_ph_d   = w_ph_q;
		w_ou_d   = w_ou_q;
		w_in_d   = w_in_q;
		c_ph_d   = c_ph_q;
		c_ou_d   = c_ou_q;
		c_in_d   = c_in_q;
		cnt_a_d  = cnt_a_q;
		cnt_b_d  = cnt_b_q;
		j_d      = j_q;
		p_d      = p_q;
		comp_d   = comp_q;
		mode_d   = mode_q;
		scan_b_d = scan_b_q;
		res_d    = res_q;
		re_a     = 1'b0;
		re_b     = 1'b0;
		ra_a     = '0;
		ra_b     = '0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_f     = '0;
		fin_s     = '0;
		fin_ph    = w_ph_q;
		fin_ou    = w_ou_q;
		fin_in    = w_in_q;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						KIND_LOAD_A: begin
							if (cnt_a_q < CAP) begin
								we_a    = 1'b1;
								cnt_a_d = cnt_a_q + 1'b1;
							end
							c_ph_d = 1'b0;
							c_ou_d = '0;
							c_in_d = '0;
						end
						KIND_LOAD_B: begin
							if (cnt_b_q < CAP) begin
								we_b    = 1'b1;
								cnt_b_d = cnt_b_q + 1'b1;
							end
							c_ph_d = 1'b0;
							c_ou_d = '0;
							c_in_d = '0;
						end
						KIND_CLEAR: begin
							cnt_a_d = '0;
							cnt_b_d = '0;
							c_ph_d  = 1'b0;
							c_ou_d  = '0;
							c_in_d  = '0;
						end
						default: begin
							w_ph_d  = c_ph_q;
							w_ou_d  = c_ou_q;
							w_in_d  = c_in_q;
							peek_d  = 1'b0;
							state_d = S_SETUP;
						end
					endcase
				end
			end
			S_SETUP: begin
				case (cfg.operation)
					OP_PRODUCT: begin
						if ((w_ou_q >= OW'(cx)) || (cy == '0) || (w_in_q >= cy)) begin
							fin = 1'b1;
						end else begin
							re_a = 1'b1;
							re_b = 1'b1;
							ra_a = cfg.order_b_first ? w_in_q[AW-1:0] : w_ou_q[AW-1:0];
							ra_b = cfg.order_b_first ? w_ou_q[AW-1:0] : w_in_q[AW-1:0];
							state_d = S_PROD;
						end
					end
					OP_COMPLEMENT: begin
						if ((OW + 1)'(w_ou_q) + 1'b1 >= UNIV) begin
							fin = 1'b1;
						end else begin
							p_d      = w_ou_q + 1'b1;
							w_ou_d   = w_ou_q + 1'b1;
							comp_d   = 1'b1;
							mode_d   = MODE_NOTIN;
							scan_b_d = cfg.order_b_first;
							j_d      = '0;
							re_a     = !cfg.order_b_first;
							re_b     = cfg.order_b_first;
							state_d  = (cx == '0) ? S_CHECK : S_SCAN;
						end
					end
					default: begin
						if (!ps_valid) begin
							fin = 1'b1;
						end else if (w_ou_q >= OW'(ns)) begin
							if (!w_ph_q && ps1_valid) begin
								w_ph_d = 1'b1;
								w_ou_d = '0;
							end else begin
								fin = 1'b1;
							end
						end else begin
							re_a     = 1'b1;
							re_b     = 1'b1;
							ra_a     = ps_src_a ? w_ou_q[AW-1:0] : '0;
							ra_b     = ps_src_a ? '0 : w_ou_q[AW-1:0];
							w_ou_d   = w_ou_q + 1'b1;
							comp_d   = 1'b0;
							mode_d   = ps_mode;
							scan_b_d = ps_src_a;
							j_d      = '0;
							state_d  = ((ps_mode == MODE_ALL) || (no == '0)) ? S_CHECK : S_SCAN;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					if (mode_q == MODE_IN) begin
						fin       = 1'b1;
						fin_found = 1'b1;
						fin_f     = cand[15:0];
					end else begin
						state_d = S_SETUP;
					end
				end else if ((NW + 1)'(j_q) + 1'b1 < (NW + 1)'(scan_n)) begin
					re_a = !scan_b_q;
					re_b = scan_b_q;
					ra_a = j_q + 1'b1;
					ra_b = j_q + 1'b1;
					j_d  = j_q + 1'b1;
				end else if (mode_q == MODE_NOTIN) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_f     = cand[15:0];
				end else begin
					state_d = S_SETUP;
				end
			end
			S_CHECK: begin
				if (mode_q != MODE_IN) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_f     = cand[15:0];
				end else begin
					state_d = S_SETUP;
				end
			end
			S_PROD: begin
				fin       = 1'b1;
				fin_found = 1'b1;
				fin_f     = x_rd;
				fin_s     = y_rd;
				if (in_inc >= (NW + 1)'(cy)) begin
					fin_in = '0;
					fin_ou = w_ou_q + 1'b1;
				end else begin
					fin_in = in_inc[NW-1:0];
				end
			end
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			if (!peek_q) begin
				if (fin_found) begin
					c_ph_d = fin_ph;
					c_ou_d = fin_ou;
					c_in_d = fin_in;
					w_ph_d = fin_ph;
					w_ou_d = fin_ou;
					w_in_d = fin_in;
					res_d.first_value  = fin_f;
					res_d.second_value = fin_s;
					res_d.valid_res    = 1'b1;
					res_d.last         = 1'b0;
					peek_d  = 1'b1;
					state_d = S_SETUP;
				end else begin
					res_d   = '0;
					state_d = S_DONE;
				end
			end else begin
				res_d.last = !fin_found;
				state_d    = S_DONE;
			end
		end

		if (rewind) begin
			c_ph_d = 1'b0;
			c_ou_d = '0;
			c_in_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			peek_q  <= 1'b0;
			c_ph_q  <= 1'b0;
			c_ou_q  <= '0;
			c_in_q  <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
		end else begin
			state_q <= state_d;
			peek_q  <= peek_d;
			c_ph_q  <= c_ph_d;
			c_ou_q  <= c_ou_d;
			c_in_q  <= c_in_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
		end
	end

	always_ff @(posedge clk) begin
		w_ph_q   <= w_ph_d;
		w_ou_q   <= w_ou_d;
		w_in_q   <= w_in_d;
		j_q      <= j_d;
		p_q      <= p_d;
		comp_q   <= comp_d;
		mode_q   <= mode_d;
		scan_b_q <= scan_b_d;
		res_q    <= res_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

FILE: hw/rtl/set_operation_engine_unit.sv
// Top level of the set operation engine: APB registers, stream ports, output register.
// Depends on soe_pkg and soe_core.
//
// Loads and clears are taken in S_IDLE. A fetch runs the result search twice, once to find the
// next result element and once more to see whether it is the final one, then hands the item
// over in S_DONE. In the search each candidate is read from its set memory (S_SETUP), then the
// entries of the other set are scanned for membership (S_SCAN) where the operation needs it.
// A product fetch reads one pair from both set memories; a complement fetch scans the chosen
// set once per value from 1 up.
module set_operation_engine_unit import soe_pkg::*; #(
	parameter int SET_CAPACITY = DEF_SET_CAPACITY,
	parameter int UNIVERSE_END = DEF_UNIVERSE_END
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] element
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] first_value, [31:16] second_value
	output logic        m_tuser,   // [0] valid_res
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	soe_cfg_t cfg_q;
	soe_req_t req;
	soe_res_t res;
	logic     cfg_wr, res_valid, res_ready;
	logic     m_tvalid_q;
	soe_res_t m_res_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_OPERATION:     cfg_q.operation     <= pwdata[2:0];
				REG_ORDER_B_FIRST: cfg_q.order_b_first <= pwdata[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OPERATION:     prdata = {29'd0, cfg_q.operation};
			REG_ORDER_B_FIRST: prdata = {31'd0, cfg_q.order_b_first};
			default:           prdata = '0;
		endcase
	end

	assign req = {s_tuser, s_tdata};

	soe_core #(
		.SET_CAPACITY(SET_CAPACITY),
		.UNIVERSE_END(UNIVERSE_END)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req       (req),
		.req_ready (s_tready),
		.cfg       (cfg_q),
		.rewind    (cfg_wr),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) m_res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_res_q.second_value, m_res_q.first_value};
	assign m_tuser  = m_res_q.valid_res;
	assign m_tlast  = m_res_q.last;

endmodule

FILE: tb/set_operation_engine_unit_test.sv
// Self-checking testbench for set_operation_engine_unit: directed table, then random set sequences.
// Expected items come from a local model of the set operations; depends on soe_pkg and the DUT.
`timescale 1ns / 100ps

module set_operation_engine_unit_test;
	import soe_pkg::*;

	localparam int SET_CAP     = DEF_SET_CAPACITY;
	localparam int UNIV_END    = DEF_UNIVERSE_END;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int TOTAL_ITEMS = 720;
	localparam int SETTLE      = 32;
	localparam int HOLD_AT     = 120;
	localparam int HOLD_CYCLES = 400;

	localparam logic [2:0] OP_UNUSED_7 = 3'd7;

	// candidate filter of one scan pass
	localparam int TAKE_ALL  = 0;
	localparam int TAKE_HIT  = 1;
	localparam int TAKE_MISS = 2;

	typedef struct packed {
		logic        is_write;
		logic        reg_sel;
		logic [1:0]  kind;
		logic [15:0] data;
		logic        typed;
		soe_res_t    want;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [15:0] element
	logic [1:0]  s_tuser  = '0;    // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [15:0] first_value, [31:16] second_value
	logic        m_tuser;          // [0] valid_res
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	set_operation_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// set model state
	logic [2:0] op_reg    = OP_UNION;
	logic       bfirst    = 1'b0;
	int         set_a [SET_CAP];
	int         set_b [SET_CAP];
	int         count_a   = 0;
	int         count_b   = 0;
	int         outer_pos = 0;
	int         inner_pos = 0;
	int         pass_no   = 0;

	soe_res_t   due_results[$];
	stim_row_t  stim_rows[$];
	int         error_count   = 0;
	int         results_seen  = 0;
	int         items_sent    = 0;
	int         cycle_count   = 0;
	int         hold_left     = 0;
	int         send_idle_pct = 12;
	int         recv_idle_pct = 82;

	function automatic bit in_set(bit use_b, int n, int v);
		for (int i = 0; i < n; i++)
			if ((use_b ? set_b[i] : set_a[i]) == v)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit pass_plan(int ph, output bit src_a, output int mode);
		src_a = 1'b1;
		mode  = TAKE_ALL;
		case (op_reg)
		OP_UNION: begin
			if (ph > 1) return 1'b0;
			src_a = (ph == 0);
			mode  = (ph == 0) ? TAKE_ALL : TAKE_MISS;
		end
		OP_INTERSECT: begin
			if (ph > 0) return 1'b0;
			mode = TAKE_HIT;
		end
		OP_DIFF: begin
			if (ph > 0) return 1'b0;
			src_a = !bfirst;
			mode  = TAKE_MISS;
		end
		OP_SYMDIFF: begin
			if (ph > 1) return 1'b0;
			src_a = (ph == 0);
			mode  = TAKE_MISS;
		end
		default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	task automatic next_element(inout int ph, inout int ou, inout int inn,
			output bit got, output int f, output int s);
		int  cx, cy, ns, no, mode, dmode, v, p;
		bit  src_a, dsrc, hit, done;
		got  = 1'b0;
		f    = 0;
		s    = 0;
		cx   = bfirst ? count_b : count_a;
		cy   = bfirst ? count_a : count_b;
		done = 1'b0;
		if (op_reg == OP_PRODUCT) begin
			if (ou < cx && cy != 0 && inn < cy) begin
				f = bfirst ? set_b[ou] : set_a[ou];
				s = bfirst ? set_a[inn] : set_b[inn];
				inn++;
				if (inn >= cy) begin
					inn = 0;
					ou++;
				end
				got = 1'b1;
			end
		end else if (op_reg == OP_COMPLEMENT) begin
			while (!got && ou + 1 < UNIV_END) begin
				p = ou + 1;
				ou++;
				if (!in_set(bfirst, cx, p)) begin
					f   = p;
					got = 1'b1;
				end
			end
		end else begin
			while (!got && !done) begin
				if (!pass_plan(ph, src_a, mode)) begin
					done = 1'b1;
				end else begin
					ns = src_a ? count_a : count_b;
					no = src_a ? count_b : count_a;
					while (!got && ou < ns) begin
						v = src_a ? set_a[ou] : set_b[ou];
						ou++;
						hit = in_set(src_a, no, v);
						if (mode == TAKE_ALL || (mode == TAKE_HIT && hit) ||
								(mode == TAKE_MISS && !hit)) begin
							f   = v;
							got = 1'b1;
						end
					end
					if (!got) begin
						if (ph >= 1 || !pass_plan(ph + 1, dsrc, dmode)) begin
							done = 1'b1;
						end else begin
							ph++;
							ou = 0;
						end
					end
				end
			end
		end
	endtask

	task automatic rewind_result();
		outer_pos = 0;
		inner_pos = 0;
		pass_no   = 0;
	endtask

	task automatic apply_item(input logic [1:0] k, input logic [15:0] e,
			output bit has_res, output soe_res_t r);
		int ph, ou, inn, f, s, ph2, ou2, in2, f2, s2;
		bit got, more;
		r       = '0;
		has_res = 1'b0;
		case (k)
		KIND_LOAD_A: begin
			if (count_a < SET_CAP) begin
				set_a[count_a] = $signed(e);
				count_a++;
			end
			rewind_result();
		end
		KIND_LOAD_B: begin
			if (count_b < SET_CAP) begin
				set_b[count_b] = $signed(e);
				count_b++;
			end
			rewind_result();
		end
		KIND_CLEAR: begin
			count_a = 0;
			count_b = 0;
			rewind_result();
		end
		default: begin
			has_res = 1'b1;
			ph  = pass_no;
			ou  = outer_pos;
			inn = inner_pos;
			next_element(ph, ou, inn, got, f, s);
			if (got) begin
				ph2 = ph;
				ou2 = ou;
				in2 = inn;
				next_element(ph2, ou2, in2, more, f2, s2);
				pass_no   = ph;
				outer_pos = ou;
				inner_pos = inn;
				r.first_value  = f[15:0];
				r.second_value = s[15:0];
				r.valid_res    = 1'b1;
				r.last         = !more;
			end
		end
		endcase
	endtask

	// valid stays high between back-to-back items; it drops only on a gap
	task automatic send_item(input logic [1:0] k, input logic [15:0] e, input logic typed_on,
			input soe_res_t typed_res, output soe_res_t r);
		bit has_res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= e;
		do @(posedge clk); while (!s_tready);
		apply_item(k, e, has_res, r);
		if (has_res)
			due_results.insert(due_results.size(), typed_on ? typed_res : r);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (sel == REG_OPERATION)
			op_reg = val[2:0];
		else
			bfirst = val[0];
		rewind_result();
	endtask

	task automatic add_row(input stim_row_t row);
		stim_rows.insert(stim_rows.size(), row);
	endtask

	function automatic stim_row_t reg_row(logic sel, logic [15:0] v);
		stim_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_sel  = sel;
		row.data     = v;
		return row;
	endfunction

	function automatic stim_row_t item_row(logic [1:0] k, logic [15:0] d);
		stim_row_t row;
		row = '0;
		row.kind = k;
		row.data = d;
		return row;
	endfunction

	function automatic stim_row_t checked_row(logic [1:0] k, logic [15:0] d, logic [15:0] f,
			logic [15:0] s, logic v, logic l);
		stim_row_t row;
		row = item_row(k, d);
		row.typed = 1'b1;
		row.want  = '{first_value: f, second_value: s, valid_res: v, last: l};
		return row;
	endfunction

	function automatic int pick_count();
		int c;
		c = $urandom_range(9);
		if (c == 0) return 0;
		if (c <= 6) return $urandom_range(1, 5);
		if (c <= 8) return $urandom_range(6, 16);
		return $urandom_range(17, 20);
	endfunction

	function automatic logic [15:0] pick_element(int style);
		int e;
		case (style)
		0: e = $urandom_range(7) - 3;
		1: e = $urandom_range(105);
		2: e = $urandom;
		default: begin
			case ($urandom_range(6))
			0: e = 16'h8000;
			1: e = 16'h7fff;
			2: e = 16'hffff;
			3: e = 0;
			4: e = 1;
			5: e = UNIV_END - 1;
			default: e = UNIV_END;
			endcase
		end
		endcase
		return e[15:0];
	endfunction

	task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : rx_check
		soe_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h %b %b",
					$time, m_tdata, m_tuser, m_tlast);
				error_count++;
			end else begin
				want = due_results.pop_front();
				report_field("first_value", want.first_value, m_tdata[15:0]);
				report_field("second_value", want.second_value, m_tdata[31:16]);
				report_field("valid_res", 16'(want.valid_res), 16'(m_tuser));
				report_field("last", 16'(want.last), 16'(m_tlast));
			end
			results_seen++;
			if (results_seen == HOLD_AT)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		soe_res_t r;
		int       style, na, nb, cap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: union with empty A, extremes, every operation, unused code, clear
		add_row(reg_row(REG_OPERATION, 16'(OP_UNION)));
		add_row(reg_row(REG_ORDER_B_FIRST, 16'd0));
		add_row(checked_row(KIND_FETCH, 16'hffff, 16'h0, 16'h0, 1'b0, 1'b0));
		add_row(item_row(KIND_LOAD_B, 16'h0005));
		add_row(item_row(KIND_LOAD_B, 16'h8000));
		add_row(checked_row(KIND_FETCH, 16'h0000, 16'h0005, 16'h0, 1'b1, 1'b0));
		add_row(checked_row(KIND_FETCH, 16'h0000, 16'h8000, 16'h0, 1'b1, 1'b1));
		add_row(checked_row(KIND_FETCH, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0));
		add_row(item_row(KIND_LOAD_A, 16'h7fff));
		add_row(item_row(KIND_LOAD_A, 16'h0005));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(reg_row(REG_OPERATION, 16'(OP_INTERSECT)));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(reg_row(REG_OPERATION, 16'(OP_DIFF)));
		add_row(reg_row(REG_ORDER_B_FIRST, 16'd1));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(reg_row(REG_OPERATION, 16'(OP_SYMDIFF)));
		add_row(reg_row(REG_ORDER_B_FIRST, 16'd0));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(reg_row(REG_OPERATION, 16'(OP_PRODUCT)));
		add_row(reg_row(REG_ORDER_B_FIRST, 16'd1));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(reg_row(REG_OPERATION, 16'(OP_COMPLEMENT)));
		add_row(reg_row(REG_ORDER_B_FIRST, 16'd0));
		add_row(item_row(KIND_FETCH, 16'h0000));
		add_row(item_row(KIND_FETCH, 16'hffff));
		add_row(reg_row(REG_OPERATION, 16'(OP_UNUSED_7)));
		add_row(checked_row(KIND_FETCH, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0));
		add_row(item_row(KIND_CLEAR, 16'hffff));
		add_row(reg_row(REG_OPERATION, 16'(OP_UNION)));
		add_row(checked_row(KIND_FETCH, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0));

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_write) begin
				wait_idle();
				write_reg(stim_rows[i].reg_sel, 32'(stim_rows[i].data));
			end else begin
				send_item(stim_rows[i].kind, stim_rows[i].data, stim_rows[i].typed,
					stim_rows[i].want, r);
			end
		end

		// random part: one configuration, new loads (mostly after a clear), then a run of fetches per sequence
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent < 260) begin
				send_idle_pct = 12;
				recv_idle_pct = 82;
			end else if (items_sent < 500) begin
				send_idle_pct = 82;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_idle();
			write_reg(REG_OPERATION, $urandom_range(7));
			write_reg(REG_ORDER_B_FIRST, $urandom_range(1));
			style = $urandom_range(3);
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 8))
					send_item(2'($urandom_range(3)), 16'($urandom), 1'b0, '0, r);
			if ($urandom_range(5) != 0)
				send_item(KIND_CLEAR, 16'($urandom), 1'b0, '0, r);
			na = pick_count();
			nb = pick_count();
			while (na + nb > 0) begin
				if (na > 0 && (nb == 0 || $urandom_range(1) == 1)) begin
					send_item(KIND_LOAD_A, pick_element(style), 1'b0, '0, r);
					na--;
				end else begin
					send_item(KIND_LOAD_B, pick_element(style), 1'b0, '0, r);
					nb--;
				end
			end
			cap = ($urandom_range(7) == 0) ? 300 : 40;
			for (int n = 0; n < cap; n++) begin
				// a load in the middle of a result run rewinds it
				if ($urandom_range(19) == 0)
					send_item($urandom_range(1) ? KIND_LOAD_A : KIND_LOAD_B,
						pick_element(style), 1'b0, '0, r);
				send_item(KIND_FETCH, 16'($urandom), 1'b0, '0, r);
				if (!r.valid_res && $urandom_range(1) == 1)
					break;
			end
		end

		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/soe_pkg.sv
hw/rtl/soe_core.sv
hw/rtl/set_operation_engine_unit.sv
tb/set_operation_engine_unit_test.sv
